>>> sv/ppsub_pkg.sv
// ----------------------------------------------------------------------------
// ppsub_pkg
// Shared types and constants for the packet phase substitution block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsub_pkg;

  localparam int DW         = 32;   // CORDIC datapath width
  localparam int GUARD      = 12;   // guard bits below Q1.15
  localparam int MAX_STAGES = 24;
  localparam int PROD_W     = 62;   // magnitude times 1/K product
  localparam int SCALE      = 30;   // 1/K is Q0.30

  localparam logic [29:0] INV_K = 30'd652032874;

  localparam logic [PROD_W-1:0] PROD_HALF  = PROD_W'(1) << (SCALE - 1);
  localparam logic signed [DW-1:0] ROUND_HALF = DW'(1) << (GUARD - 1);

  // atan(2^-k) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURN [0:MAX_STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // side information that travels with a request down the pipeline
  typedef struct packed {
    logic               kind;
    logic               store;
    logic               zero;
    logic               pass;
    logic               beyond;
    logic signed [15:0] si;
    logic signed [15:0] sq;
  } ppsub_tag_t;

  typedef struct packed {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic               beyond_reference;
  } ppsub_res_t;

endpackage

`default_nettype wire

>>> sv/ppsub_if.sv
// ----------------------------------------------------------------------------
// ppsub_if
// Valid/ready channel interfaces for samples in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppsub_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] value_i;
  logic signed [15:0] value_q;
  logic               sop;

  modport source(output valid, kind, value_i, value_q, sop, input ready);
  modport sink(input valid, kind, value_i, value_q, sop, output ready);
endinterface

interface ppsub_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;
  logic               beyond_reference;

  modport source(output valid, out_i, out_q, beyond_reference, input ready);
  modport sink(input valid, out_i, out_q, beyond_reference, output ready);
endinterface

`default_nettype wire

>>> sv/ppsub_vec_cell.sv
// ----------------------------------------------------------------------------
// ppsub_vec_cell
// One registered CORDIC vectoring micro-rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsub_vec_cell
  import ppsub_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ppsub_tag_t           in_tag,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  logic        [DW-1:0] in_z,
  output logic                 out_valid,
  output ppsub_tag_t           out_tag,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic        [DW-1:0] out_z
);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  assign dx = in_x >>> STAGE;
  assign dy = in_y >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_tag <= in_tag;
    if (in_y < 0) begin
      out_x <= in_x - dy;
      out_y <= in_y + dx;
      out_z <= in_z - ATAN_TURN[STAGE];
    end else begin
      out_x <= in_x + dy;
      out_y <= in_y - dx;
      out_z <= in_z + ATAN_TURN[STAGE];
    end
  end

endmodule

`default_nettype wire

>>> sv/ppsub_rot_cell.sv
// ----------------------------------------------------------------------------
// ppsub_rot_cell
// One registered CORDIC rotation micro-rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsub_rot_cell
  import ppsub_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ppsub_tag_t           in_tag,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  logic signed [DW-1:0] in_z,
  output logic                 out_valid,
  output ppsub_tag_t           out_tag,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic signed [DW-1:0] out_z
);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] step;

  assign dx   = in_x >>> STAGE;
  assign dy   = in_y >>> STAGE;
  assign step = $signed(ATAN_TURN[STAGE]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_tag <= in_tag;
    if (in_z >= 0) begin
      out_x <= in_x - dy;
      out_y <= in_y + dx;
      out_z <= in_z - step;
    end else begin
      out_x <= in_x + dy;
      out_y <= in_y - dx;
      out_z <= in_z + step;
    end
  end

endmodule

`default_nettype wire

>>> sv/ppsub_fifo.sv
// ----------------------------------------------------------------------------
// ppsub_fifo
// Result buffer with registered read feeding the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsub_fifo
  import ppsub_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  ppsub_res_t wr_data,
  ppsub_out_if.source results
);

  localparam int DEPTH = 2 ** AW;

  ppsub_res_t mem [DEPTH];
  logic [AW:0] wr_ptr;
  logic [AW:0] rd_ptr;
  logic        out_valid;
  ppsub_res_t  out_data;
  logic        load;

  assign load = (wr_ptr != rd_ptr) && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr    <= rd_ptr + 1'b1;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_data;
    end
    if (load) begin
      out_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  assign results.valid            = out_valid;
  assign results.out_i            = out_data.out_i;
  assign results.out_q            = out_data.out_q;
  assign results.beyond_reference = out_data.beyond_reference;

endmodule

`default_nettype wire

>>> sv/packet_phase_substitution.sv
// ----------------------------------------------------------------------------
// packet_phase_substitution
// Replaces each sample's phase by a stored per-position reference phase.
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    kind, value_i, value_q, sop
//   results   out  valid/ready    out_i, out_q, beyond_reference
//
// One request per clock while ready is high. A sample passes the input register,
// the vectoring row, the m1, m2 and rot[0] registers, the rotation row and the
// result buffer. Reference requests give no result. The pipeline never stalls:
// ready drops only when the result buffer (2**clog2(2*CORDIC_STAGES+8) entries)
// would be full counting samples still in flight. Synchronous reset empties the
// pipeline and clears the reference count and position; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_phase_substitution
  import ppsub_pkg::*;
#(
  parameter int REF_DEPTH     = 1024,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  ppsub_in_if.sink    samples,
  ppsub_out_if.source results
);

  localparam int S          = CORDIC_STAGES;
  localparam int AW         = $clog2(REF_DEPTH);
  localparam int CW         = $clog2(REF_DEPTH + 1);
  localparam int FIFO_AW    = $clog2(2 * CORDIC_STAGES + 8);
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;
  localparam int PW         = FIFO_AW + 1;

  // accept and bookkeeping
  logic          in_acc;
  logic [CW-1:0] count;
  logic [CW-1:0] position;
  logic [CW-1:0] pos_step;
  logic [PW-1:0] pending;
  logic [PW-1:0] pending_next;
  ppsub_tag_t    tag_in;
  logic [AW-1:0] addr_in;
  logic          out_acc;

  // vectoring row
  logic                 vec_valid [S+1];
  ppsub_tag_t           vec_tag   [S+1];
  logic signed [DW-1:0] vec_x     [S+1];
  logic signed [DW-1:0] vec_y     [S+1];
  logic        [DW-1:0] vec_z     [S+1];
  logic [AW-1:0]        vec_addr  [S+1];

  // reference table and magnitude scaling
  logic [15:0]       ref_phase [REF_DEPTH];
  logic [15:0]       new_phase;
  logic [DW-1:0]     mag_u;
  logic              m1_valid;
  ppsub_tag_t        m1_tag;
  logic [PROD_W-1:0] m1_prod;
  logic [15:0]       m1_phase;
  logic [PROD_W-1:0] m1_round;
  logic              m2_valid;
  ppsub_tag_t        m2_tag;
  logic [PROD_W-1:0] m2_prod;
  logic [15:0]       m2_phase;
  logic [PROD_W-1:0] m2_round;
  logic              flip;

  // rotation row
  logic                 rot_valid [S+1];
  ppsub_tag_t           rot_tag   [S+1];
  logic signed [DW-1:0] rot_x     [S+1];
  logic signed [DW-1:0] rot_y     [S+1];
  logic signed [DW-1:0] rot_z     [S+1];

  logic       fifo_wr;
  ppsub_res_t fifo_data;

  function automatic logic signed [15:0] round_sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    r = (v + ROUND_HALF) >>> GUARD;
    if (r > 32767) begin
      return 16'sh7FFF;
    end else if (r < -32768) begin
      return -16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

  assign in_acc        = samples.valid && samples.ready;
  assign out_acc       = results.valid && results.ready;
  assign samples.ready = pending < PW'(FIFO_DEPTH);

  always_comb begin
    pending_next = pending;
    if (in_acc && !samples.kind) begin
      pending_next = pending_next + 1'b1;
    end
    if (out_acc) begin
      pending_next = pending_next - 1'b1;
    end
  end

  assign pos_step = samples.sop ? '0 :
                    (position < CW'(REF_DEPTH)) ? position + 1'b1 : position;

  always_comb begin
    tag_in.kind   = samples.kind;
    tag_in.store  = samples.kind && (count < CW'(REF_DEPTH));
    tag_in.zero   = (samples.value_i == 16'sd0) && (samples.value_q == 16'sd0);
    tag_in.pass   = (count == '0) || (pos_step >= count);
    tag_in.beyond = (count != '0) && (pos_step >= count);
    tag_in.si     = samples.value_i;
    tag_in.sq     = samples.value_q;
    addr_in       = samples.kind ? count[AW-1:0] : pos_step[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      position     <= '0;
      pending      <= '0;
      vec_valid[0] <= 1'b0;
    end else begin
      pending      <= pending_next;
      vec_valid[0] <= in_acc;
      if (in_acc) begin
        if (samples.kind) begin
          if (tag_in.store) begin
            count <= count + 1'b1;
          end
        end else begin
          position <= pos_step;
        end
      end
    end
  end

  // input register: scale by 2^GUARD, fold left half plane by a half turn
  always_ff @(posedge clk) begin
    vec_tag[0]  <= tag_in;
    vec_addr[0] <= addr_in;
    if (samples.value_i < 0) begin
      vec_x[0] <= -(DW'(samples.value_i) <<< GUARD);
      vec_y[0] <= -(DW'(samples.value_q) <<< GUARD);
      vec_z[0] <= 32'h8000_0000;
    end else begin
      vec_x[0] <= DW'(samples.value_i) <<< GUARD;
      vec_y[0] <= DW'(samples.value_q) <<< GUARD;
      vec_z[0] <= '0;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_vec
    ppsub_vec_cell #(.STAGE(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vec_valid[k]),
      .in_tag   (vec_tag[k]),
      .in_x     (vec_x[k]),
      .in_y     (vec_y[k]),
      .in_z     (vec_z[k]),
      .out_valid(vec_valid[k+1]),
      .out_tag  (vec_tag[k+1]),
      .out_x    (vec_x[k+1]),
      .out_y    (vec_y[k+1]),
      .out_z    (vec_z[k+1])
    );

    always_ff @(posedge clk) begin
      vec_addr[k+1] <= vec_addr[k];
    end
  end

  assign new_phase = vec_tag[S].zero ? 16'h0000 : 16'((vec_z[S] + 32'h0000_8000) >> 16);
  assign mag_u     = vec_x[S];

  always_ff @(posedge clk) begin
    if (vec_valid[S] && vec_tag[S].store) begin
      ref_phase[vec_addr[S]] <= new_phase;
    end
    if (vec_valid[S] && !vec_tag[S].kind && !vec_tag[S].pass) begin
      m1_phase <= ref_phase[vec_addr[S]];
    end
  end

  assign m1_round = m1_prod + PROD_HALF;
  assign m2_round = m2_prod + PROD_HALF;
  assign flip     = m2_phase[15] ^ m2_phase[14];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid     <= 1'b0;
      m2_valid     <= 1'b0;
      rot_valid[0] <= 1'b0;
    end else begin
      m1_valid     <= vec_valid[S];
      m2_valid     <= m1_valid;
      rot_valid[0] <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_tag     <= vec_tag[S];
    m1_prod    <= mag_u * INV_K;
    m2_tag     <= m1_tag;
    m2_prod    <= m1_round[PROD_W-1:SCALE] * INV_K;
    m2_phase   <= m1_phase;
    rot_tag[0] <= m2_tag;
    rot_y[0]   <= '0;
    if (flip) begin
      rot_x[0] <= -$signed(m2_round[SCALE+DW-1:SCALE]);
      rot_z[0] <= $signed({m2_phase, 16'h0000} + 32'h8000_0000);
    end else begin
      rot_x[0] <= $signed(m2_round[SCALE+DW-1:SCALE]);
      rot_z[0] <= $signed({m2_phase, 16'h0000});
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_rot
    ppsub_rot_cell #(.STAGE(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (rot_valid[k]),
      .in_tag   (rot_tag[k]),
      .in_x     (rot_x[k]),
      .in_y     (rot_y[k]),
      .in_z     (rot_z[k]),
      .out_valid(rot_valid[k+1]),
      .out_tag  (rot_tag[k+1]),
      .out_x    (rot_x[k+1]),
      .out_y    (rot_y[k+1]),
      .out_z    (rot_z[k+1])
    );
  end

  assign fifo_wr = rot_valid[S] && !rot_tag[S].kind;

  always_comb begin
    fifo_data.beyond_reference = rot_tag[S].beyond;
    if (rot_tag[S].pass) begin
      fifo_data.out_i = rot_tag[S].si;
      fifo_data.out_q = rot_tag[S].sq;
    end else begin
      fifo_data.out_i = round_sat(rot_x[S]);
      fifo_data.out_q = round_sat(rot_y[S]);
    end
  end

  ppsub_fifo #(.AW(FIFO_AW)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fifo_wr),
    .wr_data(fifo_data),
    .results(results)
  );

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PW'(FIFO_DEPTH))
    else $error("result credit count above buffer depth");

  a_store_below_count: assert property (@(posedge clk) disable iff (rst)
    (vec_valid[S] && vec_tag[S].store) |-> (CW'(vec_addr[S]) < count))
    else $error("reference store at or past loaded count");

  a_full_stays_full: assert property (@(posedge clk) disable iff (rst)
    (in_acc && samples.kind && (count == CW'(REF_DEPTH))) |=> (count == CW'(REF_DEPTH)))
    else $error("reference appended to a full table");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= CW'(REF_DEPTH))
    else $error("position past table depth");

endmodule

`default_nettype wire

>>> tb/ppsub_phase_monitor.sv
// ----------------------------------------------------------------------------
// ppsub_phase_monitor
// Watches the sample and result channels of packet_phase_substitution. Accepted
// requests update a local copy of the reference table, count and
// position; each data sample queues its predicted output, which is compared
// field by field with the next accepted result.
// ----------------------------------------------------------------------------
module ppsub_phase_monitor
  import ppsub_pkg::ppsub_res_t;
#(
  parameter int   REF_DEPTH      = 1024,
  parameter int   CORDIC_STAGES  = 16,
  parameter logic REFERENCE_KIND = 1'b1
) (
  input  logic clk,
  input  logic rst,
  ppsub_in_if  samples,
  ppsub_out_if results,
  output int   mismatches,
  output int   outstanding
);

  localparam int     FRAC_GUARD = 12;
  localparam int     LUT_STAGES = 24;
  localparam longint RECIP_GAIN = 64'sd652032874;
  localparam longint ATAN_LUT [0:LUT_STAGES-1] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic [15:0] phase_table [REF_DEPTH];
  int          loaded_refs;
  int          sample_pos;
  ppsub_res_t  expected_results [$];

  function automatic void cordic_vector(input longint xi, input longint yi,
                                        output longint ang, output longint mag);
    longint x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'h80000000;
    end
    for (int k = 0; k < CORDIC_STAGES && k < LUT_STAGES; k++) begin
      dx = x >>> k;
      dy = y >>> k;
      if (y < 0) begin
        x -= dy;
        y += dx;
        z -= ATAN_LUT[k];
      end else begin
        x += dy;
        y -= dx;
        z += ATAN_LUT[k];
      end
    end
    ang = z;
    mag = x;
  endfunction

  function automatic void cordic_rotate(input longint m, input logic [15:0] ph,
                                        output longint ox, output longint oy);
    logic [31:0] z;
    longint x, y, zs, dx, dy;
    z = {ph, 16'h0000};
    // second and third quadrant: fold by a half turn
    if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
      m = -m;
      z = z + 32'h80000000;
    end
    zs = $signed(z);
    x = m;
    y = 0;
    for (int k = 0; k < CORDIC_STAGES && k < LUT_STAGES; k++) begin
      dx = x >>> k;
      dy = y >>> k;
      if (zs >= 0) begin
        x -= dy;
        y += dx;
        zs -= ATAN_LUT[k];
      end else begin
        x += dy;
        y -= dx;
        zs += ATAN_LUT[k];
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic logic [15:0] reference_angle(input logic signed [15:0] vi,
                                                  input logic signed [15:0] vq);
    longint ang, mag, rounded;
    if (vi == 0 && vq == 0)
      return 16'h0000;
    cordic_vector(longint'(vi) * (longint'(1) << FRAC_GUARD),
                  longint'(vq) * (longint'(1) << FRAC_GUARD), ang, mag);
    rounded = ang + 64'h8000;
    return rounded[31:16];
  endfunction

  function automatic logic signed [15:0] sat_q15(input longint v);
    longint r;
    r = (v + (longint'(1) << (FRAC_GUARD - 1))) >>> FRAC_GUARD;
    if (r > 32767)
      r = 32767;
    else if (r < -32768)
      r = -32768;
    return r[15:0];
  endfunction

  function automatic void substitute_phase(input logic kind,
                                           input logic signed [15:0] vi,
                                           input logic signed [15:0] vq,
                                           input logic ps);
    ppsub_res_t res;
    longint ang, mag, ox, oy;
    if (kind == REFERENCE_KIND) begin
      if (loaded_refs < REF_DEPTH) begin
        phase_table[loaded_refs] = reference_angle(vi, vq);
        loaded_refs++;
      end
      return;
    end
    if (ps)
      sample_pos = 0;
    else if (sample_pos < REF_DEPTH)
      sample_pos++;
    res.beyond_reference = 1'b0;
    if (loaded_refs == 0 || sample_pos >= loaded_refs) begin
      res.out_i = vi;
      res.out_q = vq;
      res.beyond_reference = (loaded_refs != 0);
    end else begin
      cordic_vector(longint'(vi) * (longint'(1) << FRAC_GUARD),
                    longint'(vq) * (longint'(1) << FRAC_GUARD), ang, mag);
      // undo the gain of both CORDIC passes
      mag = (mag * RECIP_GAIN + (longint'(1) << 29)) >>> 30;
      mag = (mag * RECIP_GAIN + (longint'(1) << 29)) >>> 30;
      cordic_rotate(mag, phase_table[sample_pos], ox, oy);
      res.out_i = sat_q15(ox);
      res.out_q = sat_q15(oy);
    end
    expected_results.insert(expected_results.size(), res);
  endfunction

  always @(posedge clk) begin
    ppsub_res_t want;
    if (rst) begin
      loaded_refs = 0;
      sample_pos  = 0;
      expected_results.delete();
      mismatches  = 0;
    end else begin
      if (samples.valid && samples.ready)
        substitute_phase(samples.kind, samples.value_i, samples.value_q,
                         samples.sop);
      if (results.valid && results.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_i %0d out_q %0d beyond_reference %0d",
                 results.out_i, results.out_q, results.beyond_reference);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (results.out_i !== want.out_i) begin
            $error("out_i: expected %0d, got %0d", want.out_i, results.out_i);
            mismatches++;
          end
          if (results.out_q !== want.out_q) begin
            $error("out_q: expected %0d, got %0d", want.out_q, results.out_q);
            mismatches++;
          end
          if (results.beyond_reference !== want.beyond_reference) begin
            $error("beyond_reference: expected %0d, got %0d",
                   want.beyond_reference, results.beyond_reference);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> tb/packet_phase_substitution_test.sv
// ----------------------------------------------------------------------------
// packet_phase_substitution_test
// Stimulus and verdict for packet_phase_substitution. A directed opening
// covers pass-through before any reference, extreme and zero references,
// ignored tags and the edge of the loaded table; random packets with
// interleaved reference bursts then fill the table, appends to the full
// table are dropped, and a short packet runs over the full table. Both
// channels idle at random; results are checked by ppsub_phase_monitor.
// ----------------------------------------------------------------------------
module packet_phase_substitution_test;

  localparam int   REF_DEPTH       = 1024;
  localparam int   CORDIC_STAGES   = 16;
  localparam int   RANDOM_REQUESTS = 1630;
  localparam int   QUIET_LIMIT     = 1000;
  localparam int   DRAIN_CYCLES    = 2 * CORDIC_STAGES + 16;
  localparam logic KIND_SAMPLE     = 1'b0;
  localparam logic KIND_REFERENCE  = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles = 0;
  int   requests_sent = 0;
  int   refs_loaded = 0;
  bit   tx_calm;
  bit   rx_calm;

  ppsub_in_if  samples ();
  ppsub_out_if results ();

  packet_phase_substitution #(
    .REF_DEPTH(REF_DEPTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .results(results)
  );

  ppsub_phase_monitor #(
    .REF_DEPTH(REF_DEPTH),
    .CORDIC_STAGES(CORDIC_STAGES),
    .REFERENCE_KIND(KIND_REFERENCE)
  ) monitor (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .results(results),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic kind, input logic [15:0] vi,
                              input logic [15:0] vq, input logic ps);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 31) == 0)
      tx_calm = !tx_calm;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples.valid   <= 1'b1;
    samples.kind    <= kind;
    samples.value_i <= vi;
    samples.value_q <= vq;
    samples.sop     <= ps;
    do @(posedge clk); while (samples.ready !== 1'b1);
    @(negedge clk);
    if (kind == KIND_SAMPLE) begin
      requests_sent++;
    end else if (refs_loaded < REF_DEPTH) begin
      refs_loaded++;
      requests_sent++;
    end
  endtask

  // result side: random stalls between requests, with calm stretches
  initial begin
    int gap;
    results.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 31) == 0)
        rx_calm = !rx_calm;
      if (gap > 0) begin
        results.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (results.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int  choice;
    int  len;
    int  n;
    bit  broken;
    samples.valid   = 1'b0;
    samples.kind    = KIND_SAMPLE;
    samples.value_i = 16'h0000;
    samples.value_q = 16'h0000;
    samples.sop     = 1'b0;
    tx_calm = 1'($urandom);
    rx_calm = 1'($urandom);
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no reference yet: plain pass-through
    send_request(KIND_SAMPLE, 16'h7FFF, 16'h8000, 1'b1);
    send_request(KIND_SAMPLE, 16'h8000, 16'h7FFF, 1'b0);
    send_request(KIND_SAMPLE, 16'h0000, 16'h0000, 1'b0);
    // references: zero, extremes, folded half plane, stray tag
    send_request(KIND_REFERENCE, 16'h0000, 16'h0000, 1'b0);
    send_request(KIND_REFERENCE, 16'h7FFF, 16'h7FFF, 1'b0);
    send_request(KIND_REFERENCE, 16'h8000, 16'h8000, 1'b0);
    send_request(KIND_REFERENCE, 16'h8000, 16'h0000, 1'b0);
    send_request(KIND_REFERENCE, 16'h0000, 16'h8000, 1'b0);
    send_request(KIND_REFERENCE, 16'h0000, 16'h7FFF, 1'b0);
    send_request(KIND_REFERENCE, 16'hFFFF, 16'h0001, 1'b0);
    send_request(KIND_REFERENCE, 16'h3039, 16'hF752, 1'b1);
    // a packet across the end of the loaded table, then a short new packet
    send_request(KIND_SAMPLE, 16'h8000, 16'h8000, 1'b1);
    send_request(KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 1'b0);
    send_request(KIND_SAMPLE, 16'h0000, 16'h0000, 1'b0);
    send_request(KIND_SAMPLE, 16'h8000, 16'h0000, 1'b0);
    send_request(KIND_SAMPLE, 16'h0001, 16'hFFFF, 1'b0);
    send_request(KIND_SAMPLE, 16'h7FFF, 16'h8000, 1'b0);
    send_request(KIND_SAMPLE, 16'h1234, 16'hABCD, 1'b0);
    send_request(KIND_SAMPLE, 16'h8000, 16'h7FFF, 1'b0);
    send_request(KIND_SAMPLE, 16'h4000, 16'hC000, 1'b0);
    send_request(KIND_SAMPLE, 16'h0064, 16'h00C8, 1'b1);
    send_request(KIND_SAMPLE, 16'hFF9C, 16'h0032, 1'b0);

    // budget counts the references still needed to fill the table
    while (requests_sent + (REF_DEPTH - refs_loaded) < RANDOM_REQUESTS) begin
      choice = $urandom_range(0, 9);
      if (choice < 4 && refs_loaded < REF_DEPTH) begin
        repeat ($urandom_range(1, 96))
          send_request(KIND_REFERENCE, pick_value(), pick_value(), 1'($urandom));
      end else if (choice == 9) begin
        repeat ($urandom_range(1, 4))
          send_request($urandom_range(0, 1) ? KIND_REFERENCE : KIND_SAMPLE,
                       pick_value(), pick_value(), 1'($urandom));
      end else begin
        if (refs_loaded <= 128 && $urandom_range(0, 3) == 0) begin
          len = refs_loaded - 2 + $urandom_range(0, 4);
          if (len < 0)
            len = 0;
        end else begin
          len = $urandom_range(0, 40);
        end
        broken = ($urandom_range(0, 7) == 0);
        send_request(KIND_SAMPLE, pick_value(), pick_value(), !broken);
        for (n = 0; n < len; n++) begin
          if (refs_loaded < REF_DEPTH && $urandom_range(0, 15) == 0)
            send_request(KIND_REFERENCE, pick_value(), pick_value(), 1'($urandom));
          send_request(KIND_SAMPLE, pick_value(), pick_value(),
                       $urandom_range(0, 31) == 0);
        end
      end
    end

    while (refs_loaded < REF_DEPTH)
      send_request(KIND_REFERENCE, pick_value(), pick_value(), 1'($urandom));
    // table full: these are dropped
    repeat (3) send_request(KIND_REFERENCE, pick_value(), pick_value(), 1'b0);

    samples.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);

    // short packet over the full table
    send_request(KIND_SAMPLE, pick_value(), pick_value(), 1'b1);
    repeat (8) send_request(KIND_SAMPLE, pick_value(), pick_value(), 1'b0);

    samples.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
